FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL that asserts.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: rtl/bpsr_pkg.sv
// ---------------------------------------------------------------------------
// bpsr_pkg
// Shared types and constants of the bidirectional PWM speed ramp.
// ---------------------------------------------------------------------------
`default_nettype none

package bpsr_pkg;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_DWELL  = 2'd2
    } t_mode;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEP     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DWELL_STEPS   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_SHIFT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_DEADBAND = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_LIMIT   = 3'd4;

    localparam logic [6:0]  RST_RAMP_STEP     = 7'd1;
    localparam logic [15:0] RST_DWELL_STEPS   = 16'd1;
    localparam logic [1:0]  RST_DUTY_SHIFT    = 2'd2;
    localparam logic [9:0]  RST_DUTY_DEADBAND = 10'd623;
    localparam logic [6:0]  RST_SPEED_LIMIT   = 7'd100;

    typedef struct packed {
        logic [6:0]  ramp_step;
        logic [15:0] dwell_steps;
        logic [1:0]  duty_shift;
        logic [9:0]  duty_deadband;
        logic [6:0]  speed_limit;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/bpsr_ctrl.sv
// ---------------------------------------------------------------------------
// bpsr_ctrl
// Ramp state machine: target clamp, dwell counter and speed slew step.
// ---------------------------------------------------------------------------
`default_nettype none

module bpsr_ctrl #(
    parameter int SPEED_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_kind,
    input  logic signed [SPEED_BITS-1:0] i_target,
    input  bpsr_pkg::t_cfg               i_cfg,
    output logic signed [SPEED_BITS-1:0] o_speed_next,
    output bpsr_pkg::t_mode              o_mode_next,
    output logic                         o_at_target_next
);

    localparam int CW = ((SPEED_BITS > 8) ? SPEED_BITS : 8) + 2;
    localparam logic signed [CW-1:0] SPEED_MAX_X = CW'((1 << (SPEED_BITS - 1)) - 1);

    bpsr_pkg::t_mode               r_mode, n_mode;
    logic signed [SPEED_BITS-1:0]  r_cur, n_cur;
    logic signed [SPEED_BITS-1:0]  r_want, n_want;
    logic [15:0]                   r_dwell, n_dwell;
    logic [15:0]                   dwell_dec;
    logic                          steady;

    assign dwell_dec = (r_dwell != 16'd0) ? r_dwell - 16'd1 : 16'd0;
    assign steady    = (r_cur == r_want);

    // Next state
    always_comb begin
        n_mode = r_mode;
        if (i_kind) begin
            unique case (r_mode)
                bpsr_pkg::MODE_CHANGE: begin
                    n_mode = steady ? bpsr_pkg::MODE_STEADY : bpsr_pkg::MODE_DWELL;
                end
                bpsr_pkg::MODE_DWELL: begin
                    n_mode = (dwell_dec == 16'd0) ? bpsr_pkg::MODE_CHANGE
                                                  : bpsr_pkg::MODE_DWELL;
                end
                default: begin
                    n_mode = steady ? bpsr_pkg::MODE_STEADY : bpsr_pkg::MODE_CHANGE;
                end
            endcase
        end
    end

    // Datapath outputs of the state machine
    always_comb begin
        logic signed [CW-1:0] cur_x;
        logic signed [CW-1:0] want_x;
        logic signed [CW-1:0] step_x;
        logic signed [CW-1:0] lim_x;
        logic signed [CW-1:0] t_x;
        logic signed [CW-1:0] mv_x;
        cur_x  = CW'(r_cur);
        want_x = CW'(r_want);
        step_x = CW'(signed'({1'b0, i_cfg.ramp_step}));
        lim_x  = CW'(signed'({1'b0, i_cfg.speed_limit}));
        t_x    = CW'(i_target);
        n_cur   = r_cur;
        n_want  = r_want;
        n_dwell = r_dwell;
        if (lim_x > SPEED_MAX_X) begin
            lim_x = SPEED_MAX_X;
        end
        if (t_x > lim_x) begin
            t_x = lim_x;
        end
        if (t_x < -lim_x) begin
            t_x = -lim_x;
        end
        if (want_x > cur_x) begin
            mv_x = cur_x + step_x;
            if (mv_x > want_x) begin
                mv_x = want_x;
            end
        end else begin
            mv_x = cur_x - step_x;
            if (mv_x < want_x) begin
                mv_x = want_x;
            end
        end
        if (!i_kind) begin
            n_want = SPEED_BITS'(t_x);
        end else begin
            n_dwell = dwell_dec;
            if (n_mode == bpsr_pkg::MODE_CHANGE) begin
                n_cur   = SPEED_BITS'(mv_x);
                n_dwell = i_cfg.dwell_steps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bpsr_pkg::MODE_STEADY;
            r_cur   <= '0;
            r_want  <= '0;
            r_dwell <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_cur   <= n_cur;
            r_want  <= n_want;
            r_dwell <= n_dwell;
        end
    end

    assign o_speed_next     = n_cur;
    assign o_mode_next      = n_mode;
    assign o_at_target_next = (n_cur == n_want);

endmodule

`default_nettype wire

FILE: rtl/bpsr_duty.sv
// ---------------------------------------------------------------------------
// bpsr_duty
// Map a signed speed to forward and reverse PWM duty with deadband offset.
// ---------------------------------------------------------------------------
`default_nettype none

module bpsr_duty #(
    parameter int SPEED_BITS = 8,
    parameter int DUTY_BITS  = 11
) (
    input  logic signed [SPEED_BITS-1:0] i_speed,
    input  logic [1:0]                   i_shift,
    input  logic [9:0]                   i_deadband,
    output logic [DUTY_BITS-1:0]         o_fwd,
    output logic [DUTY_BITS-1:0]         o_rev
);

    localparam int SW0 = (SPEED_BITS + 3 > 10) ? SPEED_BITS + 3 : 10;
    localparam int SW  = ((SW0 > DUTY_BITS) ? SW0 : DUTY_BITS) + 1;
    localparam logic [SW-1:0] DUTY_MAX = SW'((1 << DUTY_BITS) - 1);

    logic [SPEED_BITS-1:0] mag;
    logic [SW-1:0]         sum;
    logic [DUTY_BITS-1:0]  duty;

    assign mag  = i_speed[SPEED_BITS-1] ? SPEED_BITS'(-i_speed) : i_speed;
    assign sum  = (SW'(mag) << i_shift) + SW'(i_deadband);
    // Saturate at full scale
    assign duty = (sum > DUTY_MAX) ? DUTY_BITS'(DUTY_MAX) : DUTY_BITS'(sum);

    assign o_fwd = (!i_speed[SPEED_BITS-1] && (i_speed != '0)) ? duty : '0;
    assign o_rev = i_speed[SPEED_BITS-1] ? duty : '0;

endmodule

`default_nettype wire

FILE: rtl/bidir_pwm_speed_ramp_unit.sv
// ---------------------------------------------------------------------------
// bidir_pwm_speed_ramp_unit: signed speed ramp with forward/reverse PWM duty.
// Result path: an accepted request is held in the input register, then loaded into the result register.
// Throughput: one request per cycle while the result is drained; the state update commits on advance.
// Reset: synchronous active-low; state to steady at speed 0, config to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module bidir_pwm_speed_ramp_unit #(
    parameter int SPEED_BITS = 8,
    parameter int DUTY_BITS  = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [bpsr_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bpsr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic signed [SPEED_BITS-1:0]         i_target_speed,
    // Result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [DUTY_BITS-1:0]                 o_fwd_duty,
    output logic [DUTY_BITS-1:0]                 o_rev_duty,
    output logic signed [SPEED_BITS-1:0]         o_speed_now,
    output logic [1:0]                           o_mode,
    output logic                                 o_at_target
);

    // Configuration registers
    bpsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step     <= bpsr_pkg::RST_RAMP_STEP;
            r_cfg.dwell_steps   <= bpsr_pkg::RST_DWELL_STEPS;
            r_cfg.duty_shift    <= bpsr_pkg::RST_DUTY_SHIFT;
            r_cfg.duty_deadband <= bpsr_pkg::RST_DUTY_DEADBAND;
            r_cfg.speed_limit   <= bpsr_pkg::RST_SPEED_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpsr_pkg::CFG_RAMP_STEP:     r_cfg.ramp_step     <= i_cfg_data[6:0];
                bpsr_pkg::CFG_DWELL_STEPS:   r_cfg.dwell_steps   <= i_cfg_data[15:0];
                bpsr_pkg::CFG_DUTY_SHIFT:    r_cfg.duty_shift    <= i_cfg_data[1:0];
                bpsr_pkg::CFG_DUTY_DEADBAND: r_cfg.duty_deadband <= i_cfg_data[9:0];
                bpsr_pkg::CFG_SPEED_LIMIT:   r_cfg.speed_limit   <= i_cfg_data[6:0];
                default: begin
                    // Drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Input register: holds one request until the result register can take it.
    logic                         r_in_valid;
    logic                         r_kind;
    logic signed [SPEED_BITS-1:0] r_target;
    logic                         advance;

    // Advance the held request whenever the result slot is free or being drained.
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind   <= i_kind;
            r_target <= i_target_speed;
        end
    end

    // Ramp state machine; its state commits on advance.
    logic signed [SPEED_BITS-1:0] speed_next;
    bpsr_pkg::t_mode              mode_next;
    logic                         at_target_next;

    bpsr_ctrl #(
        .SPEED_BITS (SPEED_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (advance),
        .i_kind           (r_kind),
        .i_target         (r_target),
        .i_cfg            (r_cfg),
        .o_speed_next     (speed_next),
        .o_mode_next      (mode_next),
        .o_at_target_next (at_target_next)
    );

    // Duty mapping of the post-update speed
    logic [DUTY_BITS-1:0] fwd_next;
    logic [DUTY_BITS-1:0] rev_next;

    bpsr_duty #(
        .SPEED_BITS (SPEED_BITS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_duty (
        .i_speed    (speed_next),
        .i_shift    (r_cfg.duty_shift),
        .i_deadband (r_cfg.duty_deadband),
        .o_fwd      (fwd_next),
        .o_rev      (rev_next)
    );

    // Result register: load on advance, hold while stalled.
    logic                         r_out_valid;
    logic [DUTY_BITS-1:0]         r_fwd;
    logic [DUTY_BITS-1:0]         r_rev;
    logic signed [SPEED_BITS-1:0] r_speed;
    logic [1:0]                   r_mode;
    logic                         r_at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fwd   <= fwd_next;
            r_rev   <= rev_next;
            r_speed <= speed_next;
            r_mode  <= 2'(mode_next);
            r_at    <= at_target_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fwd_duty  = r_fwd;
    assign o_rev_duty  = r_rev;
    assign o_speed_now = r_speed;
    assign o_mode      = r_mode;
    assign o_at_target = r_at;

    // Assertions
    logic both_duty_on;
    logic zero_speed_out;
    logic duty_off;
    logic held_slot_free;

    assign both_duty_on   = o_out_valid && (o_fwd_duty != '0) && (o_rev_duty != '0);
    assign zero_speed_out = o_out_valid && (o_speed_now == '0);
    assign duty_off       = (o_fwd_duty == '0) && (o_rev_duty == '0);
    assign held_slot_free = r_in_valid && !r_out_valid;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_one_direction, i_clk, i_rst_n, both_duty_on, "both duties active")
    `ASSERT_CLK(a_zero_speed_idle, i_clk, i_rst_n, zero_speed_out |-> duty_off, "duty at zero speed")
    `ASSERT_CLK(a_free_slot_fills, i_clk, i_rst_n, held_slot_free |=> r_out_valid, "held request stuck")

endmodule

`default_nettype wire
